/* rtl/mlfq_pkg.sv */
// mlfq_pkg: command and status types shared by the scheduler controller and datapath
`default_nettype none

package mlfq_pkg;

  typedef struct packed {
    logic latch;
    logic push;
    logic select;
    logic load_task;
    logic rd_work;
    logic exec;
    logic idle_out;
  } mlfq_cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic any_ready;
    logic out_free;
  } mlfq_status_t;

  localparam int unsigned LEVELS_RESET = 4;

endpackage

`default_nettype wire

/* rtl/mlfq_ram.sv */
// mlfq_ram: generic simple dual-port ram, one write and one registered read port
`default_nettype none

module mlfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/mlfq_ctrl.sv */
// mlfq_ctrl: sequencer that steps one tick request through push, select, load and execute
`default_nettype none

module mlfq_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire mlfq_pkg::mlfq_status_t st,
  output mlfq_pkg::mlfq_cmd_t        cmd
);

  import mlfq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SELECT,
    S_LOAD,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_SELECT;
      end
      S_SELECT: begin
        priority if (st.cur_valid) begin
          cmd.rd_work = 1'b1;
          state_next  = S_EXEC;
        end else if (st.any_ready) begin
          cmd.select = 1'b1;
          state_next = S_LOAD;
        end else if (st.out_free) begin
          cmd.idle_out = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_SELECT;
        end
      end
      S_LOAD: begin
        cmd.load_task = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        if (st.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

/* rtl/mlfq_dp.sv */
// mlfq_dp: level queues, work table, running task state and result register
`default_nettype none

module mlfq_dp #(
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned MAX_TASKS  = 16,
  parameter int unsigned WORK_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [3:0]             cfg_wdata,
  input  wire logic                   arrival_valid,
  input  wire logic [3:0]             arrival_task,
  input  wire logic [15:0]            arrival_ticks,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        run_valid,
  output logic [3:0]                  run_task,
  output logic [2:0]                  run_level,
  output logic                        task_done,
  input  wire mlfq_pkg::mlfq_cmd_t    cmd,
  output mlfq_pkg::mlfq_status_t      st
);

  import mlfq_pkg::*;

  localparam int unsigned TASK_W     = $clog2(MAX_TASKS);
  localparam int unsigned LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_TASKS + 1);
  localparam int unsigned FIFO_DEPTH = MAX_LEVELS * MAX_TASKS;
  localparam int unsigned FA_W       = $clog2(FIFO_DEPTH);
  localparam logic [3:0]  MAXL4      = 4'(MAX_LEVELS);

  function automatic logic [TASK_W-1:0] task_wrap(input logic [3:0] v);
    logic [8:0] r;
    r = {5'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 9'(MAX_TASKS)) begin
        r = r - 9'(MAX_TASKS);
      end
    end
    return r[TASK_W-1:0];
  endfunction

  // configuration
  logic [3:0]       levels_in_use;
  logic [LVL_W-1:0] last_lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= 4'(LEVELS_RESET);
    end else if (cfg_we) begin
      levels_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (levels_in_use == 4'd0) begin
      last_lvl = '0;
    end else if (levels_in_use > MAXL4) begin
      last_lvl = LVL_W'(MAX_LEVELS - 1);
    end else begin
      last_lvl = LVL_W'(levels_in_use - 4'd1);
    end
  end

  // latched request
  logic                  arr_valid;
  logic [TASK_W-1:0]     arr_id;
  logic [WORK_WIDTH-1:0] arr_ticks;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      arr_valid <= arrival_valid;
      arr_id    <= task_wrap(arrival_task);
      arr_ticks <= WORK_WIDTH'(arrival_ticks);
    end
  end

  // queue bookkeeping
  logic [TASK_W-1:0] head  [MAX_LEVELS];
  logic [CNT_W-1:0]  count [MAX_LEVELS];

  logic                  cur_valid;
  logic [TASK_W-1:0]     cur_task;
  logic [LVL_W-1:0]      cur_level;
  logic [7:0]            slice_left;

  logic [LVL_W-1:0]  sel_lvl;
  logic              any_ready;
  logic [LVL_W-1:0]  qidx;
  logic [TASK_W-1:0] q_head;
  logic [CNT_W-1:0]  q_count;
  logic              q_full;
  logic [TASK_W:0]   tail_sum;
  logic [TASK_W-1:0] tail_pos;
  logic [TASK_W-1:0] head_inc;
  logic [FA_W-1:0]   q_base;

  always_comb begin
    sel_lvl   = '0;
    any_ready = 1'b0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        sel_lvl   = LVL_W'(i);
        any_ready = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (cmd.push) begin
      qidx = '0;
    end else if (cmd.select) begin
      qidx = sel_lvl;
    end else begin
      qidx = cur_level + LVL_W'(1);
    end
  end

  assign q_head   = head[qidx];
  assign q_count  = count[qidx];
  assign q_full   = (q_count >= CNT_W'(MAX_TASKS));
  assign tail_sum = (TASK_W+1)'(q_head) + (TASK_W+1)'(q_count);
  assign tail_pos = (tail_sum >= (TASK_W+1)'(MAX_TASKS))
                  ? TASK_W'(tail_sum - (TASK_W+1)'(MAX_TASKS))
                  : TASK_W'(tail_sum);
  assign head_inc = (q_head == TASK_W'(MAX_TASKS - 1)) ? '0 : q_head + TASK_W'(1);
  assign q_base   = FA_W'(qidx) * FA_W'(MAX_TASKS);

  // execute step
  logic [WORK_WIDTH-1:0] work_rdata;
  logic [WORK_WIDTH-1:0] work_next;
  logic [TASK_W-1:0]     fifo_rdata;
  logic                  fin;
  logic                  can_demote;
  logic [7:0]            slice_dec;
  logic                  slice_end;
  logic                  push_ok;
  logic                  demote_ok;

  assign fin        = (work_rdata <= WORK_WIDTH'(1));
  assign work_next  = fin ? '0 : work_rdata - WORK_WIDTH'(1);
  assign can_demote = (cur_level < last_lvl);
  assign slice_dec  = (slice_left != 8'd0) ? slice_left - 8'd1 : slice_left;
  assign slice_end  = !fin && can_demote && (slice_dec == 8'd0);
  assign push_ok    = arr_valid && (arr_ticks != '0) && !q_full;
  assign demote_ok  = slice_end && !q_full;

  // memories
  logic                  fifo_we;
  logic [FA_W-1:0]       fifo_waddr;
  logic [TASK_W-1:0]     fifo_wdata;
  logic                  work_we;
  logic [TASK_W-1:0]     work_waddr;
  logic [WORK_WIDTH-1:0] work_wdata;
  logic                  work_re;
  logic [TASK_W-1:0]     work_raddr;

  assign fifo_we    = (cmd.push && push_ok) || (cmd.exec && demote_ok);
  assign fifo_waddr = q_base + FA_W'(tail_pos);
  assign fifo_wdata = cmd.push ? arr_id : cur_task;

  assign work_we    = (cmd.push && push_ok) || cmd.exec;
  assign work_waddr = cmd.push ? arr_id : cur_task;
  assign work_wdata = cmd.push ? arr_ticks : work_next;
  assign work_re    = cmd.rd_work || cmd.load_task;
  assign work_raddr = cmd.load_task ? fifo_rdata : cur_task;

  mlfq_ram #(
    .WIDTH (TASK_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .re    (cmd.select),
    .raddr (q_base + FA_W'(q_head)),
    .rdata (fifo_rdata)
  );

  mlfq_ram #(
    .WIDTH (WORK_WIDTH),
    .DEPTH (MAX_TASKS)
  ) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wdata),
    .re    (work_re),
    .raddr (work_raddr),
    .rdata (work_rdata)
  );

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (fifo_we) begin
        count[qidx] <= q_count + CNT_W'(1);
      end else if (cmd.select) begin
        count[qidx] <= q_count - CNT_W'(1);
        head[qidx]  <= head_inc;
      end
    end
  end

  // running task
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      cur_task   <= '0;
      cur_level  <= '0;
      slice_left <= '0;
    end else begin
      if (cmd.select) begin
        cur_valid  <= 1'b1;
        cur_level  <= sel_lvl;
        slice_left <= 8'd1 << sel_lvl;
      end
      if (cmd.load_task) begin
        cur_task <= fifo_rdata;
      end
      if (cmd.exec) begin
        if (fin) begin
          cur_valid <= 1'b0;
        end else if (can_demote) begin
          priority if (slice_dec != 8'd0) begin
            slice_left <= slice_dec;
          end else if (!q_full) begin
            slice_left <= slice_dec;
            cur_valid  <= 1'b0;
          end else begin
            slice_left <= 8'd1 << cur_level;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.idle_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      run_valid <= 1'b1;
      run_task  <= 4'(cur_task);
      run_level <= 3'(cur_level);
      task_done <= fin;
    end else if (cmd.idle_out) begin
      run_valid <= 1'b0;
      run_task  <= 4'd0;
      run_level <= 3'd0;
      task_done <= 1'b0;
    end
  end

  assign st.cur_valid = cur_valid;
  assign st.any_ready = any_ready;
  assign st.out_free  = !out_valid || !out_stall;

endmodule

`default_nettype wire

/* rtl/multilevel_feedback_scheduler_unit.sv */
// multilevel_feedback_scheduler_unit: top level of the multilevel feedback queue scheduler
// one request at a time: it is latched and pushed, then the running task's work is read or a task
//   is selected and loaded via the registered ram reads; it executes and the result is registered;
//   if no task is ready an idle result is registered instead; a waiting result holds exec
// reset: synchronous, clears queues, running task and result valid; levels_in_use returns to 4
`default_nettype none

module multilevel_feedback_scheduler_unit #(
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned MAX_TASKS  = 16,
  parameter int unsigned WORK_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        arrival_valid,
  input  wire logic [3:0]  arrival_task,
  input  wire logic [15:0] arrival_ticks,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             run_valid,
  output logic [3:0]       run_task,
  output logic [2:0]       run_level,
  output logic             task_done
);

  import mlfq_pkg::*;

  mlfq_cmd_t    cmd;
  mlfq_status_t st;

  mlfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mlfq_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_TASKS  (MAX_TASKS),
    .WORK_WIDTH (WORK_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .arrival_valid (arrival_valid),
    .arrival_task  (arrival_task),
    .arrival_ticks (arrival_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .run_valid     (run_valid),
    .run_task      (run_task),
    .run_level     (run_level),
    .task_done     (task_done),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

`default_nettype wire

/* rtl/mlfq_checker.sv */
// mlfq_checker: port-level assertions for the scheduler and their bind
`default_nettype none

module mlfq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       run_valid,
  input wire logic [3:0] run_task,
  input wire logic [2:0] run_level,
  input wire logic       task_done
);

  // one request in flight at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(run_valid) && $stable(run_task)
      && $stable(run_level) && $stable(task_done))
    else $error("stalled result changed");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_valid |-> run_task == 4'd0 && run_level == 3'd0 && !task_done)
    else $error("idle tick with nonzero fields");

  a_done_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && task_done |-> run_valid)
    else $error("task_done without a running task");

endmodule

bind multilevel_feedback_scheduler_unit mlfq_checker u_mlfq_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// testbench for multilevel_feedback_scheduler_unit: directed table, then random ticks checked
// against a cycle-free scheduler model
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic       ran;
    logic [3:0] id;
    logic [2:0] level;
    logic       done;
  } tick_report_t;

  typedef struct packed {
    logic         arr_v;
    logic [3:0]   arr_id;
    logic [15:0]  arr_ticks;
    logic         typed;
    tick_report_t want;
  } directed_row_t;

  localparam int LEVEL_SLOTS  = 8;
  localparam int NUM_TASKS    = 16;
  localparam int NUM_PHASES   = 14;
  localparam int PHASE_ITEMS  = 125;
  localparam int SETTLE       = 8;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        arrival_valid;
  logic [3:0]  arrival_task;
  logic [15:0] arrival_ticks;
  logic        out_valid;
  logic        out_stall;
  logic        run_valid;
  logic [3:0]  run_task;
  logic [2:0]  run_level;
  logic        task_done;

  multilevel_feedback_scheduler_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .arrival_valid (arrival_valid),
    .arrival_task  (arrival_task),
    .arrival_ticks (arrival_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .run_valid     (run_valid),
    .run_task      (run_task),
    .run_level     (run_level),
    .task_done     (task_done)
  );

  // scheduler model state
  logic [3:0]  queue_slot [LEVEL_SLOTS][NUM_TASKS];
  logic [3:0]  queue_head [LEVEL_SLOTS];
  logic [4:0]  queue_count [LEVEL_SLOTS];
  logic [15:0] work_remaining [NUM_TASKS];
  logic [3:0]  running_id;
  logic [2:0]  running_level;
  logic        running;
  logic [7:0]  slice_remaining;
  logic [3:0]  levels_reg;

  tick_report_t tick_reports_due [$];
  int mismatches;
  int reports_seen;
  int cycle_count;
  int in_gap_mode;
  int out_gap_mode;

  directed_row_t directed_rows [20] = '{
    '{1'b0, 4'd0,  16'd0,     1'b1, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd5,  16'd1,     1'b1, '{1'b1, 4'd5, 3'd0, 1'b1}},
    '{1'b1, 4'd15, 16'd0,     1'b1, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd0,  16'hffff,  1'b1, '{1'b1, 4'd0, 3'd0, 1'b0}},
    '{1'b0, 4'd15, 16'hffff,  1'b1, '{1'b1, 4'd0, 3'd1, 1'b0}},
    '{1'b1, 4'd15, 16'hffff,  1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd1,  16'd2,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd2,  16'd3,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd0,  16'd1,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd8,  16'h8000,  1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd7,  16'h7fff,  1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd10, 16'h5555,  1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd5,  16'haaaa,  1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd15, 16'd1,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b0, 4'd0,  16'd0,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b1, 4'd3,  16'd4,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b0, 4'd0,  16'd0,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b0, 4'd0,  16'd0,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b0, 4'd0,  16'd0,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}},
    '{1'b0, 4'd0,  16'd0,     1'b0, '{1'b0, 4'd0, 3'd0, 1'b0}}
  };

  int unsigned phase_levels [NUM_PHASES] = '{1, 4, 0, 8, 2, 9, 15, 3, 5, 6, 7, 10, 8, 1};

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int draw_gap(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  function bit queue_push(input int lvl, input logic [3:0] id);
    int pos;
    if (lvl >= LEVEL_SLOTS || queue_count[lvl] >= NUM_TASKS) return 1'b0;
    pos = (queue_head[lvl] + queue_count[lvl]) % NUM_TASKS;
    queue_slot[lvl][pos] = id;
    queue_count[lvl] = queue_count[lvl] + 1'b1;
    return 1'b1;
  endfunction

  function void reset_scheduler();
    for (int l = 0; l < LEVEL_SLOTS; l++) begin
      queue_head[l] = '0;
      queue_count[l] = '0;
      for (int s = 0; s < NUM_TASKS; s++) queue_slot[l][s] = '0;
    end
    for (int t = 0; t < NUM_TASKS; t++) work_remaining[t] = '0;
    running_id = '0;
    running_level = '0;
    running = 1'b0;
    slice_remaining = '0;
    levels_reg = 4'(mlfq_pkg::LEVELS_RESET);
  endfunction

  // one tick: queue the arrival, pick a task if idle, run it
  function void schedule_tick(input logic arr_v, input logic [3:0] arr_id,
                              input logic [15:0] arr_ticks, output tick_report_t rpt);
    int last;
    bit found;
    last = (levels_reg == 0) ? 0 : (levels_reg > LEVEL_SLOTS) ? LEVEL_SLOTS - 1 : levels_reg - 1;
    found = 1'b0;
    rpt = '0;
    if (arr_v && arr_ticks != 0) begin
      if (queue_push(0, arr_id)) work_remaining[arr_id] = arr_ticks;
    end
    if (!running) begin
      for (int l = 0; l < LEVEL_SLOTS; l++) begin
        if (!found && queue_count[l] != 0) begin
          found = 1'b1;
          running_id = queue_slot[l][queue_head[l]];
          queue_head[l] = queue_head[l] + 1'b1;
          queue_count[l] = queue_count[l] - 1'b1;
          running_level = 3'(l);
          slice_remaining = 8'(1 << l);
          running = 1'b1;
        end
      end
    end
    if (!running) return;
    rpt.ran = 1'b1;
    rpt.id = running_id;
    rpt.level = running_level;
    if (work_remaining[running_id] <= 1) begin
      work_remaining[running_id] = '0;
      rpt.done = 1'b1;
      running = 1'b0;
    end else begin
      work_remaining[running_id] = work_remaining[running_id] - 1'b1;
      if (running_level < last) begin
        if (slice_remaining > 0) slice_remaining = slice_remaining - 1'b1;
        if (slice_remaining == 0) begin
          if (queue_push(running_level + 1, running_id)) running = 1'b0;
          else slice_remaining = 8'(1 << running_level);
        end
      end
    end
  endfunction

  task send_request(input logic v, input logic [3:0] id, input logic [15:0] ticks,
                    output tick_report_t rpt);
    int gap;
    gap = draw_gap(in_gap_mode);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    arrival_valid <= v;
    arrival_task <= id;
    arrival_ticks <= ticks;
    do @(posedge clk); while (in_stall);
    schedule_tick(v, id, ticks, rpt);
  endtask

  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tick_reports_due.size() != 0) @(posedge clk);
  endtask

  task set_levels(input logic [3:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    levels_reg = value;
  endtask

  // result side
  initial begin
    int gap;
    tick_report_t want;
    wait (rst == 1'b0);
    forever begin
      gap = (reports_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(out_gap_mode);
      if (gap > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      reports_seen++;
      if (tick_reports_due.size() == 0) begin
        $error("unexpected result: run_valid=%0d run_task=%0d run_level=%0d task_done=%0d",
               run_valid, run_task, run_level, task_done);
        mismatches++;
      end else begin
        want = tick_reports_due.pop_front();
        if (run_valid !== want.ran) begin
          $error("run_valid: expected %0d, got %0d", want.ran, run_valid);
          mismatches++;
        end
        if (run_task !== want.id) begin
          $error("run_task: expected %0d, got %0d", want.id, run_task);
          mismatches++;
        end
        if (run_level !== want.level) begin
          $error("run_level: expected %0d, got %0d", want.level, run_level);
          mismatches++;
        end
        if (task_done !== want.done) begin
          $error("task_done: expected %0d, got %0d", want.done, task_done);
          mismatches++;
        end
      end
    end
  end

  // request side
  initial begin
    tick_report_t rpt;
    logic v;
    logic [3:0] id;
    logic [15:0] ticks;
    int arr_pct;
    int tick_max;
    int sel;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    arrival_valid = 1'b0;
    arrival_task = '0;
    arrival_ticks = '0;
    out_stall = 1'b0;
    mismatches = 0;
    reports_seen = 0;
    cycle_count = 0;
    in_gap_mode = 1;
    out_gap_mode = 2;
    reset_scheduler();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].arr_v, directed_rows[r].arr_id,
                   directed_rows[r].arr_ticks, rpt);
      tick_reports_due.push_back(directed_rows[r].typed ? directed_rows[r].want : rpt);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      repeat (SETTLE) @(posedge clk);
      set_levels(4'(phase_levels[p]));
      in_gap_mode = p % 3;
      out_gap_mode = (p + 1) % 3;
      arr_pct = (p % 3 == 0) ? 95 : (p % 3 == 1) ? 50 : 15;
      tick_max = (p % 2 == 1) ? 40 : 6;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 7 && k == 60) wait_drained();
        v = ($urandom_range(0, 99) < arr_pct);
        id = 4'($urandom_range(0, 15));
        sel = $urandom_range(0, 99);
        if (sel < 4) ticks = '0;
        else if (sel < 8) ticks = 16'($urandom_range(0, 65535));
        else if (sel < 10) ticks = 16'hffff;
        else ticks = 16'($urandom_range(1, tick_max));
        send_request(v, id, ticks, rpt);
        tick_reports_due.push_back(rpt);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
